FILE: rtl/core/sdls_pkg.sv
// Shared types and constants of the smoke detector line supervisor.
// Used by sdls_step, sdls_obuf and the top level; depends on nothing.
`default_nettype none

package sdls_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ENABLE        = 3'd0,
    REG_ALARM_CONFIRM = 3'd1,
    REG_ERROR_CONFIRM = 3'd2,
    REG_STBY_TIMEOUT  = 3'd3,
    REG_ERROR_WINDOW  = 3'd4,
    REG_ERROR_REPEAT  = 3'd5
  } sdls_reg_e;

  localparam logic [3:0]  AlarmConfirmRst = 4'd10;
  localparam logic [3:0]  ErrorConfirmRst = 4'd10;
  localparam logic [15:0] StbyTimeoutRst  = 16'd4000;
  localparam logic [9:0]  ErrorWindowRst  = 10'd300;
  localparam logic [3:0]  ErrorRepeatRst  = 4'd5;

  localparam logic [7:0] PulsesBattery = 8'd1;
  localparam logic [7:0] PulsesEol     = 8'd3;

  typedef struct packed {
    logic        enable;
    logic [3:0]  alarm_confirm_ticks;
    logic [3:0]  error_confirm_ticks;
    logic [15:0] standby_timeout_ticks;
    logic [9:0]  error_window_ticks;
    logic [3:0]  error_repeat_count;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  alarm_hold_count;
    logic [3:0]  error_level_count;
    logic [15:0] standby_tick_count;
    logic [7:0]  pulse_count;
    logic [9:0]  quiet_tick_count;
    logic [3:0]  repeat_count;
    logic        battery_hold;
    logic        eol_hold;
  } state_t;

  typedef struct packed {
    logic alarm_edge;
    logic standby_edge;
    logic error_edge;
    logic alarm_level;
    logic error_level;
    logic rearm_battery;
    logic rearm_eol;
  } item_t;

  typedef struct packed {
    logic smoke_alarm;
    logic tamper_open;
    logic tamper_close;
    logic standby_lost;
    logic low_battery;
    logic end_of_life;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/sdls_step.sv
// Next-state and result logic for one tick of the line supervisor.
// Depends on sdls_pkg.
`default_nettype none

module sdls_step import sdls_pkg::*; (
  input  cfg_t    cfg_i,
  input  state_t  state_i,
  input  item_t   item_i,
  output state_t  state_o,
  output result_t result_o
);

  always_comb begin
    logic [3:0]  a_cnt;
    logic [3:0]  e_cnt;
    logic [15:0] s_cnt;
    logic [9:0]  q_cnt;
    logic        is_batt;
    logic        held;

    state_o  = state_i;
    result_o = '0;

    // rearm acts first, even while disabled
    if (item_i.rearm_battery) state_o.battery_hold = 1'b0;
    if (item_i.rearm_eol)     state_o.eol_hold     = 1'b0;

    a_cnt   = item_i.alarm_edge ? 4'd1 : state_i.alarm_hold_count;
    e_cnt   = (state_i.error_level_count == 4'hF) ? 4'hF
                                                  : state_i.error_level_count + 4'd1;
    s_cnt   = (state_i.standby_tick_count == 16'hFFFF) ? 16'hFFFF
                                                       : state_i.standby_tick_count + 16'd1;
    q_cnt   = (state_i.quiet_tick_count == 10'h3FF) ? 10'h3FF
                                                    : state_i.quiet_tick_count + 10'd1;
    is_batt = (state_i.pulse_count == PulsesBattery);
    held    = is_batt ? state_o.battery_hold : state_o.eol_hold;

    if (cfg_i.enable) begin
      // smoke alarm confirmation
      if (a_cnt != 4'd0) begin
        if (item_i.alarm_level) begin
          a_cnt = (a_cnt == 4'hF) ? 4'hF : a_cnt + 4'd1;
          if (a_cnt >= cfg_i.alarm_confirm_ticks) begin
            result_o.smoke_alarm = 1'b1;
            a_cnt = 4'd0;
          end
        end else begin
          a_cnt = 4'd0;
        end
      end
      state_o.alarm_hold_count = a_cnt;

      // tamper by error level
      if (item_i.error_level) begin
        if (e_cnt >= cfg_i.error_confirm_ticks) begin
          result_o.tamper_open = (e_cnt == cfg_i.error_confirm_ticks);
          e_cnt = cfg_i.error_confirm_ticks;
        end
        state_o.error_level_count = e_cnt;
      end else begin
        result_o.tamper_close     = (state_i.error_level_count >= cfg_i.error_confirm_ticks);
        state_o.error_level_count = 4'd0;
      end

      // standby supervision
      if (item_i.standby_edge) begin
        state_o.standby_tick_count = 16'd0;
      end else if (s_cnt >= cfg_i.standby_timeout_ticks) begin
        state_o.standby_tick_count = 16'd0;
        result_o.standby_lost      = 1'b1;
      end else begin
        state_o.standby_tick_count = s_cnt;
      end

      // error pulse grouping
      if (item_i.error_edge) begin
        state_o.pulse_count      = (state_i.pulse_count == 8'hFF) ? 8'hFF
                                                                  : state_i.pulse_count + 8'd1;
        state_o.quiet_tick_count = 10'd0;
      end else if (q_cnt >= cfg_i.error_window_ticks) begin
        if (is_batt || state_i.pulse_count == PulsesEol) begin
          state_o.repeat_count = (state_i.repeat_count == 4'hF) ? 4'hF
                                                                : state_i.repeat_count + 4'd1;
          if (state_o.repeat_count >= cfg_i.error_repeat_count && !held) begin
            state_o.repeat_count = 4'd0;
            if (is_batt) begin
              result_o.low_battery = 1'b1;
              state_o.battery_hold = 1'b1;
            end else begin
              result_o.end_of_life = 1'b1;
              state_o.eol_hold     = 1'b1;
            end
          end
        end else begin
          state_o.repeat_count = 4'd0;
        end
        state_o.pulse_count      = 8'd0;
        state_o.quiet_tick_count = 10'd0;
      end else begin
        state_o.quiet_tick_count = q_cnt;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/sdls_obuf.sv
// Two-entry result buffer: holds a beat and a skid beat so the input side keeps
// flowing while the consumer stalls, until both entries are full. Depends on sdls_pkg.
`default_nettype none

module sdls_obuf import sdls_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  result_t in_data_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_data_o
);

  logic    head_v_q, head_v_d, skid_v_q, skid_v_d;
  result_t head_q, head_d, skid_q, skid_d;
  logic    push, pop;

  assign in_ready_o  = !skid_v_q;
  assign out_valid_o = head_v_q;
  assign out_data_o  = head_q;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = head_v_q && out_ready_i;

  always_comb begin
    head_v_d = head_v_q;
    skid_v_d = skid_v_q;
    head_d   = head_q;
    skid_d   = skid_q;
    if (pop) begin
      if (skid_v_q) begin
        head_d   = skid_q;
        skid_v_d = 1'b0;
      end else begin
        head_v_d = push;
        head_d   = in_data_i;
      end
    end else if (push) begin
      if (!head_v_q) begin
        head_v_d = 1'b1;
        head_d   = in_data_i;
      end else begin
        skid_v_d = 1'b1;
        skid_d   = in_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      head_v_q <= head_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

endmodule

`default_nettype wire

FILE: rtl/core/smoke_detector_line_supervisor.sv
// Smoke detector line supervisor: one beat per tick in, one result beat out.
// Takes one input beat every clock cycle while in_ready_o is high; each result
// enters a two-entry buffer at the edge its beat is taken and is offered from
// the next cycle once the results ahead of it have left, so a stalled consumer
// blocks input only once both entries are full. All work for a beat is a single
// pass of counter compares between the state registers and the result buffer.
// Depends on sdls_pkg, sdls_step and sdls_obuf.
`default_nettype none

module smoke_detector_line_supervisor import sdls_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                alarm_edge_i,
  input  logic                standby_edge_i,
  input  logic                error_edge_i,
  input  logic                alarm_level_i,
  input  logic                error_level_i,
  input  logic                rearm_battery_i,
  input  logic                rearm_eol_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                smoke_alarm_o,
  output logic                tamper_open_o,
  output logic                tamper_close_o,
  output logic                standby_lost_o,
  output logic                low_battery_o,
  output logic                end_of_life_o
);

  cfg_t    cfg_q, cfg_d;
  state_t  state_q, state_d;
  item_t   item;
  result_t result, out_data;
  logic    accept;

  assign item = '{alarm_edge:    alarm_edge_i,
                  standby_edge:  standby_edge_i,
                  error_edge:    error_edge_i,
                  alarm_level:   alarm_level_i,
                  error_level:   error_level_i,
                  rearm_battery: rearm_battery_i,
                  rearm_eol:     rearm_eol_i};

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_ENABLE:        cfg_d.enable                = cfg_wdata_i[0];
        REG_ALARM_CONFIRM: cfg_d.alarm_confirm_ticks   = cfg_wdata_i[3:0];
        REG_ERROR_CONFIRM: cfg_d.error_confirm_ticks   = cfg_wdata_i[3:0];
        REG_STBY_TIMEOUT:  cfg_d.standby_timeout_ticks = cfg_wdata_i[15:0];
        REG_ERROR_WINDOW:  cfg_d.error_window_ticks    = cfg_wdata_i[9:0];
        REG_ERROR_REPEAT:  cfg_d.error_repeat_count    = cfg_wdata_i[3:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  sdls_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (item),
    .state_o  (state_d),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q   <= '{enable:                1'b0,
                   alarm_confirm_ticks:   AlarmConfirmRst,
                   error_confirm_ticks:   ErrorConfirmRst,
                   standby_timeout_ticks: StbyTimeoutRst,
                   error_window_ticks:    ErrorWindowRst,
                   error_repeat_count:    ErrorRepeatRst};
      state_q <= '0;
    end else begin
      cfg_q <= cfg_d;
      if (accept) begin
        state_q <= state_d;
      end
    end
  end

  sdls_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (result),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign smoke_alarm_o  = out_data.smoke_alarm;
  assign tamper_open_o  = out_data.tamper_open;
  assign tamper_close_o = out_data.tamper_close;
  assign standby_lost_o = out_data.standby_lost;
  assign low_battery_o  = out_data.low_battery;
  assign end_of_life_o  = out_data.end_of_life;

endmodule

`default_nettype wire

FILE: rtl/core/sdls_checker.sv
// Port-level checks for the line supervisor and the bind that attaches them.
// Depends on smoke_detector_line_supervisor.
`default_nettype none

module sdls_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic smoke_alarm_o,
  input logic tamper_open_o,
  input logic tamper_close_o,
  input logic standby_lost_o,
  input logic low_battery_o,
  input logic end_of_life_o
);

  logic [5:0] fields;
  assign fields = {smoke_alarm_o, tamper_open_o, tamper_close_o,
                   standby_lost_o, low_battery_o, end_of_life_o};

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(fields))
    else $error("result beat dropped or changed while stalled");

  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted beat gave no result");

  a_pattern_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(low_battery_o && end_of_life_o))
    else $error("low battery and end of life in one beat");

  a_tamper_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(tamper_open_o && tamper_close_o))
    else $error("tamper open and close in one beat");

endmodule

bind smoke_detector_line_supervisor sdls_checker u_sdls_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .smoke_alarm_o  (smoke_alarm_o),
  .tamper_open_o  (tamper_open_o),
  .tamper_close_o (tamper_close_o),
  .standby_lost_o (standby_lost_o),
  .low_battery_o  (low_battery_o),
  .end_of_life_o  (end_of_life_o)
);

`default_nettype wire

FILE: tb/sv/sdls_tracker_pkg.sv
// Event tracker for the smoke detector line supervisor bench: predicts the
// events of every accepted tick and checks result beats against them.
// Depends on sdls_pkg for the register indexes and the beat types.
package sdls_tracker_pkg;
  import sdls_pkg::*;

  class line_event_tracker;
    cfg_t        cfg;
    state_t      st;
    result_t     due_events [$];
    int unsigned failures;
    string       event_names [6];

    function new();
      cfg.enable                = 1'b0;
      cfg.alarm_confirm_ticks   = AlarmConfirmRst;
      cfg.error_confirm_ticks   = ErrorConfirmRst;
      cfg.standby_timeout_ticks = StbyTimeoutRst;
      cfg.error_window_ticks    = ErrorWindowRst;
      cfg.error_repeat_count    = ErrorRepeatRst;
      st = '0;
      failures = 0;
      event_names = '{"smoke_alarm", "tamper_open", "tamper_close",
                      "standby_lost", "low_battery", "end_of_life"};
    endfunction

    function void set_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_ENABLE:        cfg.enable = data[0];
        REG_ALARM_CONFIRM: cfg.alarm_confirm_ticks = data[3:0];
        REG_ERROR_CONFIRM: cfg.error_confirm_ticks = data[3:0];
        REG_STBY_TIMEOUT:  cfg.standby_timeout_ticks = data[15:0];
        REG_ERROR_WINDOW:  cfg.error_window_ticks = data[9:0];
        REG_ERROR_REPEAT:  cfg.error_repeat_count = data[3:0];
        default: ;
      endcase
    endfunction

    function void take_tick(item_t it);
      result_t    ev;
      logic [3:0] lvl;
      ev = '0;
      if (it.rearm_battery) st.battery_hold = 1'b0;
      if (it.rearm_eol) st.eol_hold = 1'b0;
      if (cfg.enable) begin
        if (it.alarm_edge) st.alarm_hold_count = 4'd1;
        if (st.alarm_hold_count != 4'd0) begin
          if (it.alarm_level) begin
            if (st.alarm_hold_count != 4'hf) st.alarm_hold_count++;
            if (st.alarm_hold_count >= cfg.alarm_confirm_ticks) begin
              ev.smoke_alarm = 1'b1;
              st.alarm_hold_count = '0;
            end
          end else begin
            st.alarm_hold_count = '0;
          end
        end

        if (it.error_level) begin
          lvl = (st.error_level_count == 4'hf) ? 4'hf : st.error_level_count + 4'd1;
          if (lvl >= cfg.error_confirm_ticks) begin
            ev.tamper_open = (lvl == cfg.error_confirm_ticks);
            lvl = cfg.error_confirm_ticks;
          end
          st.error_level_count = lvl;
        end else begin
          ev.tamper_close = (st.error_level_count >= cfg.error_confirm_ticks);
          st.error_level_count = '0;
        end

        if (it.standby_edge) begin
          st.standby_tick_count = '0;
        end else begin
          if (st.standby_tick_count != 16'hffff) st.standby_tick_count++;
          if (st.standby_tick_count >= cfg.standby_timeout_ticks) begin
            st.standby_tick_count = '0;
            ev.standby_lost = 1'b1;
          end
        end

        if (it.error_edge) begin
          if (st.pulse_count != 8'hff) st.pulse_count++;
          st.quiet_tick_count = '0;
        end else begin
          if (st.quiet_tick_count != 10'h3ff) st.quiet_tick_count++;
          if (st.quiet_tick_count >= cfg.error_window_ticks) begin
            if (st.pulse_count == PulsesBattery || st.pulse_count == PulsesEol) begin
              if (st.repeat_count != 4'hf) st.repeat_count++;
              if (st.pulse_count == PulsesBattery) begin
                if (st.repeat_count >= cfg.error_repeat_count && !st.battery_hold) begin
                  ev.low_battery = 1'b1;
                  st.repeat_count = '0;
                  st.battery_hold = 1'b1;
                end
              end else if (st.repeat_count >= cfg.error_repeat_count && !st.eol_hold) begin
                ev.end_of_life = 1'b1;
                st.repeat_count = '0;
                st.eol_hold = 1'b1;
              end
            end else begin
              st.repeat_count = '0;
            end
            st.pulse_count = '0;
            st.quiet_tick_count = '0;
          end
        end
      end
      due_events.push_back(ev);
    endfunction

    function void match_events(result_t got);
      result_t want;
      if (due_events.size() == 0) begin
        $error("result beat %b arrived with no tick outstanding", got);
        failures++;
        return;
      end
      want = due_events.pop_front();
      for (int i = 0; i < 6; i++) begin
        if (got[5-i] !== want[5-i]) begin
          $error("%s: expected %b, got %b", event_names[i], want[5-i], got[5-i]);
          failures++;
        end
      end
    endfunction
  endclass

endpackage

FILE: tb/sv/testbench.sv
// Top of the smoke detector line supervisor bench: clock, reset, register
// writes, tick stimulus with bursts and gaps, and a stalling result sink.
// Depends on sdls_pkg, sdls_tracker_pkg and the supervisor RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sdls_pkg::*;
  import sdls_tracker_pkg::*;

  typedef enum int unsigned {
    DRAIN_FREE,
    DRAIN_LIGHT,
    DRAIN_HEAVY,
    DRAIN_CYCLIC
  } drain_e;

  localparam logic [CfgIdxW-1:0] RegSpare = 3'd6;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                alarm_edge_i;
  logic                standby_edge_i;
  logic                error_edge_i;
  logic                alarm_level_i;
  logic                error_level_i;
  logic                rearm_battery_i;
  logic                rearm_eol_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic                smoke_alarm_o;
  logic                tamper_open_o;
  logic                tamper_close_o;
  logic                standby_lost_o;
  logic                low_battery_o;
  logic                end_of_life_o;

  line_event_tracker tracker = new();

  int unsigned alarm_left = 0;
  int unsigned level_left = 0;
  int unsigned stby_left  = 0;
  int unsigned pulse_left = 0;
  int unsigned quiet_left = 0;
  int unsigned burst_left = 0;

  drain_e      drain_mode  = DRAIN_FREE;
  int unsigned drain_left  = 0;
  int unsigned drain_phase = 0;

  bit [6:0] tour [24] = '{
    7'b1001000, 7'b0001000, 7'b1001000, 7'b1001000, 7'b0001100, 7'b1000100,
    7'b0000100, 7'b0000000, 7'b0010000, 7'b0000000, 7'b0010000, 7'b0100000,
    7'b0010000, 7'b0010000, 7'b0010000, 7'b0000000, 7'b0010000, 7'b0010000,
    7'b0000000, 7'b0010000, 7'b0000010, 7'b0000001, 7'b1111111, 7'b0000000
  };

  smoke_detector_line_supervisor dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        tracker.take_tick({alarm_edge_i, standby_edge_i, error_edge_i, alarm_level_i,
                           error_level_i, rearm_battery_i, rearm_eol_i});
      if (out_valid_o && out_ready_i)
        tracker.match_events({smoke_alarm_o, tamper_open_o, tamper_close_o,
                              standby_lost_o, low_battery_o, end_of_life_o});
    end
  end

  always @(posedge clk_i) begin
    if (drain_left == 0) begin
      drain_mode = drain_e'($urandom_range(0, 3));
      drain_left = $urandom_range(16, 160);
    end
    drain_left--;
    drain_phase++;
    case (drain_mode)
      DRAIN_FREE:  out_ready_i <= 1'b1;
      DRAIN_LIGHT: out_ready_i <= ($urandom_range(0, 3) != 0);
      DRAIN_HEAVY: out_ready_i <= ($urandom_range(0, 3) == 0);
      default:     out_ready_i <= (drain_phase % 7 < 3);
    endcase
  end

  function automatic item_t line_sample();
    item_t       it;
    int unsigned th;
    it = item_t'(7'($urandom_range(0, 127)));
    if ($urandom_range(0, 9) == 0) return it;
    it = '0;

    th = tracker.cfg.alarm_confirm_ticks;
    if (alarm_left == 0) begin
      if ($urandom_range(0, 4) == 0) begin
        it.alarm_edge = 1'b1;
        alarm_left = $urandom_range(th > 1 ? th - 1 : 1, th + 2);
      end
    end else if ($urandom_range(0, 15) == 0) begin
      it.alarm_edge = 1'b1;
    end
    it.alarm_level = (alarm_left != 0) ? ($urandom_range(0, 19) != 0)
                                       : ($urandom_range(0, 7) == 0);
    if (alarm_left != 0) alarm_left--;

    th = tracker.cfg.error_confirm_ticks;
    if (level_left == 0 && $urandom_range(0, 6) == 0)
      level_left = $urandom_range(th > 1 ? th - 1 : 1, th + 4);
    it.error_level = (level_left != 0) ? ($urandom_range(0, 29) != 0)
                                       : ($urandom_range(0, 15) == 0);
    if (level_left != 0) level_left--;

    th = tracker.cfg.standby_timeout_ticks;
    if (stby_left == 0) begin
      it.standby_edge = 1'b1;
      stby_left = (th > 48) ? $urandom_range(1, 48) : $urandom_range(th > 1 ? th - 1 : 0, th + 1);
    end else begin
      stby_left--;
    end

    th = tracker.cfg.error_window_ticks;
    if (pulse_left == 0 && quiet_left == 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: pulse_left = 1;
        4, 5, 6, 7: pulse_left = 3;
        default:    pulse_left = $urandom_range(2, 6);
      endcase
    end
    if (pulse_left != 0) begin
      it.error_edge = 1'b1;
      pulse_left--;
      if (pulse_left == 0)
        quiet_left = (th > 40) ? $urandom_range(1, 40) : $urandom_range(th, th + 2);
    end else begin
      quiet_left--;
    end

    it.rearm_battery = ($urandom_range(0, 9) == 0);
    it.rearm_eol     = ($urandom_range(0, 9) == 0);
    return it;
  endfunction

  task automatic send_beat(item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    {alarm_edge_i, standby_edge_i, error_edge_i, alarm_level_i,
     error_level_i, rearm_battery_i, rearm_eol_i} <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (tracker.due_events.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, int unsigned value, int unsigned width);
    logic [CfgDataW-1:0] data;
    data = CfgDataW'(value);
    data = data | CfgDataW'($urandom() << width);
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    tracker.set_register(idx, data);
  endtask

  task automatic apply_setting(int unsigned en, int unsigned alarm_ticks,
                               int unsigned error_ticks, int unsigned timeout,
                               int unsigned window, int unsigned repeats);
    settle();
    write_reg(RegSpare + CfgIdxW'($urandom_range(0, 1)), $urandom(), 0);
    write_reg(REG_ALARM_CONFIRM, alarm_ticks, 4);
    write_reg(REG_ERROR_CONFIRM, error_ticks, 4);
    write_reg(REG_STBY_TIMEOUT, timeout, 16);
    write_reg(REG_ERROR_WINDOW, window, 10);
    write_reg(REG_ERROR_REPEAT, repeats, 4);
    write_reg(REG_ENABLE, en, 1);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(int unsigned count, bit pulse_storm);
    item_t it;
    for (int unsigned i = 0; i < count; i++) begin
      if (pulse_storm) begin
        it = item_t'(7'($urandom_range(0, 127)));
        it.error_edge = (i < 259);
      end else begin
        it = line_sample();
      end
      send_beat(it);
    end
  endtask

  initial begin
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_index_i     <= '0;
    cfg_wdata_i     <= '0;
    in_valid_i      <= 1'b0;
    out_ready_i     <= 1'b0;
    alarm_edge_i    <= 1'b0;
    standby_edge_i  <= 1'b0;
    error_edge_i    <= 1'b0;
    alarm_level_i   <= 1'b0;
    error_level_i   <= 1'b0;
    rearm_battery_i <= 1'b0;
    rearm_eol_i     <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_beat(7'b1111111);
    send_beat(7'b0011100);

    apply_setting(1, 3, 2, 4, 1, 1);
    foreach (tour[i]) send_beat(tour[i]);

    apply_setting(1, 0, 0, 0, 0, 0);
    send_beat(7'b0000000);
    send_beat(7'b1011100);
    send_beat(7'b0000100);

    apply_setting(1, 15, 15, 65535, 1023, 15);
    run_phase(40, 1'b0);
    apply_setting(1, 1, 1, 1, 1, 1);
    run_phase(40, 1'b0);
    apply_setting(0, $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 40),
                  $urandom_range(0, 12), $urandom_range(0, 4));
    run_phase(20, 1'b0);
    apply_setting(1, $urandom_range(1, 15), $urandom_range(1, 15), $urandom_range(1, 40), 6, 1);
    run_phase(267, 1'b1);
    repeat (2) begin
      apply_setting($urandom_range(0, 7) != 0, $urandom_range(0, 15), $urandom_range(0, 15),
                    $urandom_range(0, 40), $urandom_range(0, 12), $urandom_range(0, 4));
      run_phase(40, 1'b0);
    end
    apply_setting(1, 0, 0, 0, 0, 0);
    run_phase(30, 1'b0);

    settle();
    repeat (8) @(posedge clk_i);
    if (tracker.failures == 0 && tracker.due_events.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
